[hw/rtl/pwm_channel_duty_controller_unit_assert.svh]
// assertion macros for the pwm channel duty controller checker
`ifndef PWM_CHANNEL_DUTY_CONTROLLER_UNIT_ASSERT_SVH
`define PWM_CHANNEL_DUTY_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define PWMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwmc check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define PWMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwmc check failed");

`endif

[hw/rtl/pwmc_pkg.sv]
// shared constants, types and tables of the pwm channel duty controller
package pwmc_pkg;

  localparam int unsigned CLOCK_HZ        = 16000000;
  localparam int unsigned DUTY_FULL_SCALE = 1000;
  localparam int unsigned FREQ_CLAMP      = CLOCK_HZ / 2;
  localparam int unsigned DEFAULT_FREQ    = 1000;

  localparam int unsigned FREQ_W = 23;
  localparam int unsigned TICK_W = 17;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned PROD_W = TICK_W + DUTY_W;
  localparam int unsigned DIV_W  = 35;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);

  localparam logic [DUTY_W-1:0] DUTY_FS   = DUTY_W'(DUTY_FULL_SCALE);
  localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(DUTY_FULL_SCALE / 2);
  localparam logic [TICK_W-1:0] TICKS_MAX = TICK_W'(65536);

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_SET   = 2'd1,
    OP_STOP  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_BAD_CHAN  = 2'd1,
    ST_SKIPPED   = 2'd2,
    ST_NO_MAP    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_PWM  = 2'd2,
    MODE_KEEP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MAP_NONE    = 2'd0,
    MAP_ROUTE   = 2'd1,
    MAP_UNROUTE = 2'd2
  } map_t;

  typedef enum logic [2:0] {
    SQ_PICK_GO,
    SQ_PICK_WAIT,
    SQ_IDLE,
    SQ_EVAL,
    SQ_MUL,
    SQ_CMP_GO,
    SQ_CMP_WAIT,
    SQ_FIN
  } seq_state_t;

  // result item, first field in the msbs so status sits at bit 0
  typedef struct packed {
    logic [15:0] period_value;
    logic [1:0]  prescale_select;
    logic        map_high_byte;
    logic [3:0]  map_register;
    map_t        map_action;
    logic [15:0] compare_value;
    mode_t       output_mode;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] reg_idx;
    logic       hi;
  } pin_map_t;

  // prescaler shift for code 0..3: by 1, 8, 64, 256
  function automatic logic [3:0] presc_shift(input logic [1:0] code);
    case (code)
      2'd0:    presc_shift = 4'd0;
      2'd1:    presc_shift = 4'd3;
      2'd2:    presc_shift = 4'd6;
      default: presc_shift = 4'd8;
    endcase
  endfunction

  function automatic pin_map_t pin_lookup(input logic [6:0] pin);
    pin_map_t m;
    m = '{ok: 1'b1, reg_idx: 4'd0, hi: 1'b0};
    case (pin)
      7'd20:   m.reg_idx = 4'd0;
      7'd35:   begin m.reg_idx = 4'd0; m.hi = 1'b1; end
      7'd36:   m.reg_idx = 4'd1;
      7'd37:   begin m.reg_idx = 4'd1; m.hi = 1'b1; end
      7'd38:   m.reg_idx = 4'd2;
      7'd39:   begin m.reg_idx = 4'd2; m.hi = 1'b1; end
      7'd40:   m.reg_idx = 4'd3;
      7'd41:   begin m.reg_idx = 4'd3; m.hi = 1'b1; end
      7'd42:   m.reg_idx = 4'd4;
      7'd43:   begin m.reg_idx = 4'd4; m.hi = 1'b1; end
      7'd54:   m.reg_idx = 4'd5;
      7'd55:   begin m.reg_idx = 4'd5; m.hi = 1'b1; end
      7'd56:   m.reg_idx = 4'd6;
      7'd57:   begin m.reg_idx = 4'd6; m.hi = 1'b1; end
      7'd97:   begin m.reg_idx = 4'd7; m.hi = 1'b1; end
      7'd118:  begin m.reg_idx = 4'd8; m.hi = 1'b1; end
      7'd120:  m.reg_idx = 4'd9;
      default: m.ok = 1'b0;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/pwmc_div.sv]
// shared restoring divider, one quotient bit per cycle
module pwmc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pwmc_pkg::div_req_t req,
  output pwmc_pkg::div_rsp_t rsp
);
  import pwmc_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] num_r, num_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      num_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      // quotient bits shift in where numerator bits leave
      num_nxt = {num_r[DIV_W-2:0], fits};
      rem_nxt = fits ? DIV_W'(trial - {1'b0, den_r}) : trial[DIV_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

[hw/rtl/pwm_channel_duty_controller_unit.sv]
// top level of the four-channel pwm duty controller
//
//  channel | dir | payload                                    | transfer when
//  in_     | in  | tuser: op; tdata: channel, duty, pin       | in_tvalid & in_tready
//  out_    | out | tdata: result item                         | out_tvalid & out_tready
//  cfg_    | in  | cfg_data: frequency_hz                     | cfg_valid & cfg_ready
//
// an item holds the sequencer through eval, multiply, divide start, the divider run and
// finish when it yields a compare value, else through eval and finish only
// a frequency write or reset runs the timer pick: 1 to 4 tries,
// in_tready and cfg_ready stay low meanwhile
// reset is synchronous, active low; reset starts a pick for 1000 hz
// a result waiting in the output register stalls only the next item's finish
module pwm_channel_duty_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // channel[2:0], duty[18:3], pin_number[25:19], zeros
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], output_mode[3:2], compare_value[19:4], map_action[21:20],
  // map_register[25:22], map_high_byte[26], prescale_select[28:27],
  // period_value[44:29], zeros
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] cfg_data
);
  import pwmc_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [1:0]        pick_r, pick_nxt;
  logic [1:0]        code_r, code_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;

  // per-channel state, each entry read at the channel index of the item
  logic [DUTY_W-1:0] stored_r [4];
  logic [DUTY_W-1:0] stored_nxt [4];
  logic [3:0]        valid_r, valid_nxt;
  logic [3:0]        routed_r, routed_nxt;

  // captured item
  op_t               op_r, op_nxt;
  logic [2:0]        ch_r, ch_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic [6:0]        pin_r, pin_nxt;

  logic [DUTY_W-1:0] dc_r, dc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  div_req_t          dreq;
  div_rsp_t          drsp;

  pwmc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  logic              cfg_fire, in_fire;
  assign cfg_ready = (state_r == SQ_IDLE);
  assign in_tready = (state_r == SQ_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    logic [DIV_W-1:0] f_eff;
    logic [DIV_W-1:0] den;
    logic [1:0]       idx;
    logic             ch_ok;
    logic             rout_eff;
    logic             val_eff;
    logic [DUTY_W-1:0] d_req;
    logic [DUTY_W-1:0] d_c;
    logic             release_it;
    pin_map_t         pm;
    logic [DIV_W-1:0] cval;

    state_nxt     = state_r;
    freq_nxt      = freq_r;
    pick_nxt      = pick_r;
    code_nxt      = code_r;
    ticks_nxt     = ticks_r;
    stored_nxt    = stored_r;
    valid_nxt     = valid_r;
    routed_nxt    = routed_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    duty_nxt      = duty_r;
    pin_nxt       = pin_r;
    dc_nxt        = dc_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    dreq          = '{start: 1'b0, num: '0, den: '0};

    // effective frequency: zero means default, clamp to half the clock
    f_eff = (freq_r == '0) ? DIV_W'(DEFAULT_FREQ) : DIV_W'(freq_r);
    if (f_eff > DIV_W'(FREQ_CLAMP)) f_eff = DIV_W'(FREQ_CLAMP);
    den = f_eff << presc_shift(pick_r);

    idx        = ch_r[1:0] - 2'd1;
    ch_ok      = (ch_r >= 3'd1) && (ch_r <= 3'd4);
    rout_eff   = routed_r[idx] && (op_r != OP_INIT);
    val_eff    = valid_r[idx] && (op_r != OP_INIT);
    d_req      = (op_r == OP_START) ? stored_r[idx] : duty_r;
    d_c        = (d_req > DUTY_FS) ? DUTY_FS : d_req;
    release_it = 1'b0;
    pm         = pin_lookup(pin_r);
    cval       = drsp.quot;

    case (state_r)
      SQ_PICK_GO: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_W'(CLOCK_HZ) + (den >> 1);
        dreq.den   = den;
        state_nxt  = SQ_PICK_WAIT;
      end
      SQ_PICK_WAIT: begin
        if (drsp.done) begin
          if (drsp.quot >= DIV_W'(2) && drsp.quot <= DIV_W'(65536)) begin
            code_nxt  = pick_r;
            ticks_nxt = drsp.quot[TICK_W-1:0];
            state_nxt = SQ_IDLE;
          end else if (pick_r == 2'd3) begin
            // nothing fits: slowest prescaler, full period
            code_nxt  = 2'd3;
            ticks_nxt = TICKS_MAX;
            state_nxt = SQ_IDLE;
          end else begin
            pick_nxt  = pick_r + 2'd1;
            state_nxt = SQ_PICK_GO;
          end
        end
      end
      SQ_IDLE: begin
        if (cfg_fire) begin
          freq_nxt  = cfg_data;
          pick_nxt  = 2'd0;
          state_nxt = SQ_PICK_GO;
        end else if (in_fire) begin
          op_nxt    = op_t'(in_tuser);
          ch_nxt    = in_tdata[2:0];
          duty_nxt  = in_tdata[18:3];
          pin_nxt   = in_tdata[25:19];
          state_nxt = SQ_EVAL;
        end
      end
      SQ_EVAL: begin
        res_nxt = '{period_value: 16'(ticks_r - 1'b1), prescale_select: code_r,
                    map_high_byte: 1'b0, map_register: 4'd0, map_action: MAP_NONE,
                    compare_value: 16'd0, output_mode: MODE_KEEP, status: ST_APPLIED};
        state_nxt = SQ_FIN;
        if (!ch_ok) begin
          res_nxt.status = ST_BAD_CHAN;
        end else if (op_r == OP_STOP) begin
          release_it             = 1'b1;
          valid_nxt[idx]         = 1'b0;
          res_nxt.output_mode    = MODE_LOW;
        end else begin
          if (op_r == OP_INIT) begin
            routed_nxt[idx] = 1'b0;
            valid_nxt[idx]  = 1'b0;
          end
          if (val_eff && stored_r[idx] == d_c) begin
            res_nxt.status = ST_SKIPPED;
          end else begin
            stored_nxt[idx] = d_c;
            valid_nxt[idx]  = 1'b1;
            if (d_c == '0 || d_c >= DUTY_FS) begin
              release_it          = 1'b1;
              res_nxt.output_mode = (d_c == '0) ? MODE_LOW : MODE_HIGH;
            end else if (!rout_eff && !pm.ok) begin
              valid_nxt[idx]      = 1'b0;
              res_nxt.status      = ST_NO_MAP;
              res_nxt.output_mode = MODE_LOW;
            end else begin
              if (!rout_eff) begin
                res_nxt.map_action    = MAP_ROUTE;
                res_nxt.map_register  = pm.reg_idx;
                res_nxt.map_high_byte = pm.hi;
                routed_nxt[idx]       = 1'b1;
              end
              res_nxt.output_mode = MODE_PWM;
              dc_nxt              = d_c;
              state_nxt           = SQ_MUL;
            end
          end
        end
        // release routing: the flag drops even when no register is written
        if (release_it && rout_eff) begin
          routed_nxt[idx] = 1'b0;
          if (pm.ok) begin
            res_nxt.map_action    = MAP_UNROUTE;
            res_nxt.map_register  = pm.reg_idx;
            res_nxt.map_high_byte = pm.hi;
          end
        end
      end
      SQ_MUL: begin
        prod_nxt  = PROD_W'(ticks_r) * PROD_W'(dc_r);
        state_nxt = SQ_CMP_GO;
      end
      SQ_CMP_GO: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_W'(prod_r) + DIV_W'(DUTY_HALF);
        dreq.den   = DIV_W'(DUTY_FS);
        state_nxt  = SQ_CMP_WAIT;
      end
      SQ_CMP_WAIT: begin
        if (drsp.done) begin
          // hold the compare value inside 1..ticks-1
          if (cval == '0) cval = DIV_W'(1);
          if (cval >= DIV_W'(ticks_r)) cval = DIV_W'(ticks_r) - DIV_W'(1);
          res_nxt.compare_value = cval[15:0];
          state_nxt             = SQ_FIN;
        end
      end
      SQ_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_PICK_GO;
      freq_r      <= FREQ_W'(DEFAULT_FREQ);
      pick_r      <= 2'd0;
      code_r      <= 2'd0;
      ticks_r     <= '0;
      valid_r     <= '0;
      routed_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) stored_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      freq_r      <= freq_nxt;
      pick_r      <= pick_nxt;
      code_r      <= code_nxt;
      ticks_r     <= ticks_nxt;
      valid_r     <= valid_nxt;
      routed_r    <= routed_nxt;
      out_valid_r <= out_valid_nxt;
      stored_r    <= stored_nxt;
    end
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    duty_r <= duty_nxt;
    pin_r  <= pin_nxt;
    dc_r   <= dc_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

endmodule

[hw/rtl/pwmc_chk.sv]
// port-level checker for the pwm channel duty controller, with its bind
`include "pwm_channel_duty_controller_unit_assert.svh"

module pwmc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [22:0] cfg_data
);

  // a stalled result holds
  `PWMC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // one item at a time: busy right after an item transfer
  `PWMC_ASSERT_NXT(a_busy_after_item, in_tvalid && in_tready, !in_tready && !cfg_ready)
  // a frequency write starts the timer pick before any item
  `PWMC_ASSERT_NXT(a_busy_after_cfg, cfg_valid && cfg_ready, !in_tready)
  // bad channel leaves everything alone
  `PWMC_ASSERT_IMP(a_bad_chan, out_tvalid && out_tdata[1:0] == 2'd1,
                   out_tdata[3:2] == 2'd3 && out_tdata[19:4] == 16'd0 &&
                   out_tdata[21:20] == 2'd0)

endmodule

bind pwm_channel_duty_controller_unit pwmc_chk u_pwmc_chk (.*);
